### hdl/i2da_pkg.sv
//------------------------------------------------------------------------------
// i2da_pkg
// Shared widths, types and character codes of the decimal ASCII converter.
//------------------------------------------------------------------------------
package i2da_pkg;

   localparam int VALUE_WIDTH  = 64;
   localparam int DIGIT_COUNT  = 20;

   localparam int FIELD_W      = 64;
   localparam int ROOM_W       = 8;
   localparam int CHAR_W       = 8;
   localparam int LEN_W        = 5;

   localparam int DIG_IDX_W    = $clog2(DIGIT_COUNT);
   localparam int BIT_CNT_W    = $clog2(VALUE_WIDTH + 1);

   typedef logic [3:0]             digit_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [CHAR_W-1:0]      char_type;

   localparam char_type CHAR_ZERO  = 8'h30;
   localparam char_type CHAR_MINUS = 8'h2D;

endpackage

### hdl/i2da_req_if.sv
//------------------------------------------------------------------------------
// i2da_req_if
// Request channel: mode, value and destination room, valid/ready handshake.
//------------------------------------------------------------------------------
interface i2da_req_if
   import i2da_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              func;
   logic [FIELD_W-1:0] value;
   logic [ROOM_W-1:0]  room;

   modport source (output valid, func, value, room, input ready);
   modport sink   (input valid, func, value, room, output ready);
endinterface

### hdl/i2da_rsp_if.sv
//------------------------------------------------------------------------------
// i2da_rsp_if
// Response channel: one character item per handshake.
//------------------------------------------------------------------------------
interface i2da_rsp_if
   import i2da_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CHAR_W-1:0] text_char;
   logic             fits;
   logic [LEN_W-1:0]  total_length;
   logic             last;

   modport source (output valid, text_char, fits, total_length, last, input ready);
   modport sink   (input valid, text_char, fits, total_length, last, output ready);
endinterface

### hdl/integer_to_decimal_ascii_top.sv
//------------------------------------------------------------------------------
// integer_to_decimal_ascii_top
// Binary to decimal ASCII converter, bit-serial double dabble.
//------------------------------------------------------------------------------
// req_ch takes one item: func (0 unsigned, 1 signed), a 64-bit value and the
// room left in the destination. rsp_ch returns one item per character, most
// significant first: the ASCII code, a fits flag (position below room), the
// full text length and a last flag. Leading zeros are dropped; zero prints
// as "0"; a negative signed value prints as '-' and its magnitude.
// Sequence: the item is taken, the magnitude is shifted into the BCD digits
// one bit per cycle, then one character per cycle leaves into the output
// register when it is empty or being taken. No new item is taken until the
// last character of the current one has entered the output register.
// req_ch.ready is high while no item is in work, also while the final
// character still waits in the output register.
// A stalled receiver holds the output register and pauses emission; no
// character is dropped.
// Reset is synchronous and clears the control state; the block is idle and
// ready in the first cycle after reset.
//------------------------------------------------------------------------------
module integer_to_decimal_ascii_top
   import i2da_pkg::*;
(
   input logic        clock,
   input logic        reset,
   i2da_req_if.sink   req_ch,
   i2da_rsp_if.source rsp_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                        state_ff, state_in;
   value_type                         shift_ff, shift_in;
   digit_type [DIGIT_COUNT-1:0]       digits_ff, digits_in;
   logic [BIT_CNT_W-1:0]              bit_cnt_ff, bit_cnt_in;
   logic [DIG_IDX_W-1:0]              top_ff, top_in;
   logic [DIG_IDX_W-1:0]              dig_ff, dig_in;
   logic [LEN_W-1:0]                  pos_ff, pos_in;
   logic [LEN_W-1:0]                  total_ff, total_in;
   logic                              neg_ff, neg_in;
   logic [ROOM_W-1:0]                 room_ff, room_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   char_type                          char_ff;
   logic                              fits_ff;
   logic [LEN_W-1:0]                  total_out_ff;
   logic                              last_ff;

   logic                              req_accept;
   value_type                         value_raw;
   value_type                         magnitude;
   logic                              is_neg;
   digit_type [DIGIT_COUNT-1:0]       step_digits;
   logic [DIGIT_COUNT:0]              carry_vec;
   logic [DIG_IDX_W-1:0]              rd_idx;
   digit_type                         rd_digit;
   logic                              top_grow;
   logic [DIG_IDX_W-1:0]              top_next;
   logic                              emit_go;
   logic                              sign_slot;
   logic                              is_last;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign value_raw = req_ch.value[VALUE_WIDTH-1:0];
   assign is_neg    = req_ch.func && value_raw[VALUE_WIDTH-1];
   assign magnitude = is_neg ? VALUE_WIDTH'(~value_raw + 1'b1) : value_raw;

   // add-3 then shift, every digit cell in parallel
   always_comb begin
      digit_type adj;
      carry_vec[0] = shift_ff[VALUE_WIDTH-1];
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         adj = (digits_ff[d] >= 4'd5) ? digits_ff[d] + 4'd3 : digits_ff[d];
         step_digits[d]  = {adj[2:0], carry_vec[d]};
         carry_vec[d+1]  = adj[3];
      end
   end

   // one digit read port: top tracking while converting, output while emitting
   assign rd_idx   = (state_ff == ST_CONV) ? top_ff : dig_ff;
   assign rd_digit = digits_ff[rd_idx];
   assign top_grow = (rd_digit >= 4'd5) && (top_ff != DIG_IDX_W'(DIGIT_COUNT - 1));
   assign top_next = top_ff + DIG_IDX_W'(top_grow);

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign sign_slot = neg_ff && (pos_ff == '0);
   assign is_last   = (pos_ff == total_ff - LEN_W'(1));

   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      digits_in  = digits_ff;
      bit_cnt_in = bit_cnt_ff;
      top_in     = top_ff;
      dig_in     = dig_ff;
      pos_in     = pos_ff;
      total_in   = total_ff;
      neg_in     = neg_ff;
      room_in    = room_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               shift_in   = magnitude;
               digits_in  = '0;
               bit_cnt_in = '0;
               top_in     = '0;
               neg_in     = is_neg;
               room_in    = req_ch.room;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            shift_in   = shift_ff << 1;
            digits_in  = step_digits;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            top_in     = top_next;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
               state_in = ST_EMIT;
               pos_in   = '0;
               dig_in   = top_next;
               total_in = LEN_W'(top_next) + LEN_W'(neg_ff) + LEN_W'(1);
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + LEN_W'(1);
               end
               if (!sign_slot) begin
                  dig_in = dig_ff - DIG_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      digits_ff <= digits_in;
      top_ff    <= top_in;
      dig_ff    <= dig_in;
      pos_ff    <= pos_in;
      total_ff  <= total_in;
      neg_ff    <= neg_in;
      room_ff   <= room_in;
      if (emit_go) begin
         char_ff      <= sign_slot ? CHAR_MINUS : CHAR_ZERO + CHAR_W'(rd_digit);
         fits_ff      <= ROOM_W'(pos_ff) < room_ff;
         total_out_ff <= total_ff;
         last_ff      <= is_last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.text_char    = char_ff;
   assign rsp_ch.fits         = fits_ff;
   assign rsp_ch.total_length = total_out_ff;
   assign rsp_ch.last         = last_ff;

   a_pos_in_text: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> pos_ff < total_ff)
      else $error("emit position beyond text length");

   a_emit_no_conv: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |=> state_ff != ST_CONV)
      else $error("conversion started without returning to idle");

   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1))
      |=> (state_ff == ST_EMIT && pos_ff == '0))
      else $error("conversion did not hand over to emission");

   a_top_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV |-> BIT_CNT_W'(top_ff) <= bit_cnt_ff)
      else $error("top digit index grew faster than one per bit");

endmodule

### dv/tb_integer_to_decimal_ascii_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_integer_to_decimal_ascii_top
// Self-checking bench for the binary to decimal ASCII converter.
//------------------------------------------------------------------------------
// A directed set covers zero, the extremes of both modes and the room limits.
// Random values of every magnitude follow under four idle patterns on the
// request and response sides. Each accepted request is expanded into its
// characters by a bit-serial dabble predictor. Every response item is then
// checked against the oldest predicted character.
//------------------------------------------------------------------------------
module tb_integer_to_decimal_ascii_top;
   import i2da_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam int RESULT_LIMIT = 20;
   localparam int PHASE_ITEMS  = 112;

   typedef struct packed {
      char_type         text_char;
      logic             fits;
      logic [LEN_W-1:0] total_length;
      logic             last;
   } text_item_type;

   class decimal_text_board_type;
      text_item_type pending_chars[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      // expand one request into the characters it prints
      function void note_request(logic func, logic [FIELD_W-1:0] value,
                                 logic [ROOM_W-1:0] room);
         value_type     magnitude;
         digit_type     digits[DIGIT_COUNT];
         digit_type     nibble;
         logic          negative;
         logic          carry_in;
         logic          carry_out;
         int            b;
         int            d;
         int            top;
         int            total;
         int            count;
         int            pos;
         text_item_type item;
         magnitude = value[VALUE_WIDTH-1:0];
         negative  = func && magnitude[VALUE_WIDTH-1];
         if (negative) begin
            magnitude = -magnitude;
         end
         for (d = 0; d < DIGIT_COUNT; d++) begin
            digits[d] = '0;
         end
         for (b = VALUE_WIDTH - 1; b >= 0; b--) begin
            carry_in = magnitude[b];
            for (d = 0; d < DIGIT_COUNT; d++) begin
               nibble = digits[d];
               if (nibble >= 4'd5) begin
                  nibble = nibble + 4'd3;
               end
               carry_out = nibble[3];
               digits[d] = {nibble[2:0], carry_in};
               carry_in  = carry_out;
            end
         end
         top = 0;
         for (d = DIGIT_COUNT - 1; d > 0; d--) begin
            if (digits[d] != 0) begin
               top = d;
               break;
            end
         end
         total = top + 1 + int'(negative);
         count = (total < RESULT_LIMIT) ? total : RESULT_LIMIT;
         for (pos = 0; pos < count; pos++) begin
            if (negative && pos == 0) begin
               item.text_char = CHAR_MINUS;
            end else begin
               item.text_char = CHAR_ZERO + char_type'(digits[top - (pos - int'(negative))]);
            end
            item.fits         = (pos < int'(room));
            item.total_length = total[LEN_W-1:0];
            item.last         = (pos == count - 1);
            pending_chars.push_back(item);
         end
      endfunction

      function void check_char(text_item_type got);
         text_item_type want;
         if (pending_chars.size() == 0) begin
            $error("unexpected character item: char %h", got.text_char);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.text_char !== want.text_char) begin
            $error("text_char: expected %h, got %h", want.text_char, got.text_char);
            errors++;
         end
         if (got.fits !== want.fits) begin
            $error("fits: expected %b, got %b", want.fits, got.fits);
            errors++;
         end
         if (got.total_length !== want.total_length) begin
            $error("total_length: expected %0d, got %0d", want.total_length,
                   got.total_length);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   int                     send_idle_pct;
   int                     recv_stall_pct;
   int                     quiet_cycles = 0;
   decimal_text_board_type board;

   i2da_req_if req_ch ();
   i2da_rsp_if rsp_ch ();

   integer_to_decimal_ascii_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_char('{rsp_ch.text_char, rsp_ch.fits, rsp_ch.total_length,
                               rsp_ch.last});
         end
         if (req_ch.valid && req_ch.ready) begin
            board.note_request(req_ch.func, req_ch.value, req_ch.room);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_request(input logic func, input value_type value,
                               input logic [ROOM_W-1:0] room);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.func  <= 1'($urandom_range(1));
         req_ch.value <= {$urandom, $urandom};
         req_ch.room  <= ROOM_W'($urandom_range(255));
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= func;
      req_ch.value <= value;
      req_ch.room  <= room;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_random_request();
      logic              func;
      value_type         value;
      logic [ROOM_W-1:0] room;
      func = 1'($urandom_range(1));
      case ($urandom_range(7))
         0, 1: value = {$urandom, $urandom};
         2, 3: value = {$urandom, $urandom} >> $urandom_range(63);
         4: begin
            value = VALUE_WIDTH'(1);
            repeat ($urandom_range(19)) value = value * VALUE_WIDTH'(10);
            value = value + VALUE_WIDTH'($urandom_range(2)) - VALUE_WIDTH'(1);
         end
         5: value = VALUE_WIDTH'($urandom_range(20));
         6: begin
            value = -({$urandom, $urandom} >> $urandom_range(63));
            func  = 1'b1;
         end
         default: begin
            case ($urandom_range(3))
               0: value = '1;
               1: value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
               2: value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
               default: value = {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
            endcase
         end
      endcase
      if ($urandom_range(3) == 0) begin
         room = ROOM_W'($urandom_range(255));
      end else begin
         room = ROOM_W'($urandom_range(21));
      end
      send_request(func, value, room);
   endtask

   initial begin
      board          = new();
      clock          = 1'b0;
      reset          = 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      req_ch.valid   = 1'b0;
      req_ch.func    = 1'b0;
      req_ch.value   = '0;
      req_ch.room    = '0;
      rsp_ch.ready   = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(1'b0, 64'd0, 8'd0);
      send_request(1'b1, 64'd0, 8'd255);
      send_request(1'b0, '1, 8'd255);
      send_request(1'b0, '1, 8'd19);
      send_request(1'b1, '1, 8'd1);
      send_request(1'b1, 64'h8000_0000_0000_0000, 8'd20);
      send_request(1'b0, 64'h8000_0000_0000_0000, 8'd5);
      send_request(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 8'd21);
      send_request(1'b0, 64'd1, 8'd1);
      send_request(1'b1, 64'd9, 8'd0);
      send_request(1'b0, 64'd10, 8'd1);
      send_request(1'b0, 64'd99, 8'd2);
      send_request(1'b1, 64'd100, 8'd3);
      send_request(1'b0, 64'd99999999, 8'd8);
      send_request(1'b0, 64'd100000000, 8'd9);
      send_request(1'b0, 64'd10000000000000000000, 8'd20);
      send_request(1'b0, 64'd9999999999999999999, 8'd18);
      send_request(1'b1, -64'd1000000000000000000, 8'd254);
      send_request(1'b1, -64'd5, 8'd128);
      send_request(1'b0, 64'hAAAA_AAAA_5555_5555, 8'd127);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         repeat (PHASE_ITEMS) send_random_request();
      end
      req_ch.valid <= 1'b0;

      while (board.pending_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.errors == 0 && board.pending_chars.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
hdl/i2da_pkg.sv
hdl/i2da_req_if.sv
hdl/i2da_rsp_if.sv
hdl/integer_to_decimal_ascii_top.sv
dv/tb_integer_to_decimal_ascii_top.sv
